[design/svs_pkg.sv]
// ----------------------------------------------------------------------------
// svs_pkg
// Shared operation and status codes for the searchable value stack.
// ----------------------------------------------------------------------------
package svs_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned DEPTH_W  = 7;

	// Operation codes carried by an input item
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

	// Status codes carried by a result item
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RSVD  = 2'd3;

endpackage

[design/svs_mem.sv]
// ----------------------------------------------------------------------------
// svs_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module svs_mem
	import svs_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [VALUE_W-1:0]       wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [VALUE_W-1:0]       rd_data
);

	logic [VALUE_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/searchable_value_stack.sv]
// ----------------------------------------------------------------------------
// searchable_value_stack
// LIFO of 64-bit values with push, pop and a membership search.
// ----------------------------------------------------------------------------
// One item is handled at a time and each item gives one result item. Push,
// pop, no-op and a find on an empty stack go from acceptance to S_DONE,
// which loads the result register, and the block then returns to idle to
// take the next item. A find on a non-empty stack walks the held entries
// through the single read port of the entry memory, one entry per cycle;
// after the last entry is compared it moves to S_DONE, which loads the
// result register. A stalled result holds the block in its last state
// until the result register frees up. A push on a full stack returns status
// full, a pop on an empty stack returns status empty; neither changes
// anything. Opcode 3 is a no-op. depth_now is the low 7 bits of the entry
// count after the item. The result register lets the next item be accepted
// while a result waits.
module searchable_value_stack
	import svs_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [DEPTH_W-1:0]  depth_now
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;
	logic [VALUE_W-1:0]    key_q;
	logic                  hit_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_found_q;
	logic                  vld_s1;
	logic                  last_s1;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  found_q;
	logic [DEPTH_W-1:0]    depth_q;

	logic                  accept;
	logic                  wr_en;
	logic                  rd_en;
	logic [VALUE_W-1:0]    rd_data;
	logic                  match;
	logic                  out_free;
	logic [CW+DEPTH_W-1:0] count_wide;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign match     = (rd_data == key_q);

	// Push writes at the current top; find reads never overlap a write
	assign wr_en     = accept && (opcode == OP_PUSH) && (count_q != FULL_CNT);
	assign rd_en     = (state_q == S_SCAN) && (ptr_q != count_q);
	assign count_wide = {{DEPTH_W{1'b0}}, count_q};

	svs_mem #(
		.DEPTH (STACK_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (ptr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Sequencer: accept, scan for find, hand result to output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			hit_q        <= 1'b0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
			res_status_q <= ST_OK;
			res_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// result valid: set on load, cleared once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_found_q <= 1'b0;
						unique case (opcode)
							OP_PUSH: begin
								state_q <= S_DONE;
								if (count_q == FULL_CNT) begin
									res_status_q <= ST_FULL;
								end else begin
									res_status_q <= ST_OK;
									count_q      <= count_q + 1'b1;
								end
							end
							OP_POP: begin
								state_q <= S_DONE;
								if (count_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									res_status_q <= ST_OK;
									count_q      <= count_q - 1'b1;
								end
							end
							OP_FIND: begin
								res_status_q <= ST_OK;
								ptr_q        <= '0;
								hit_q        <= 1'b0;
								vld_s1       <= 1'b0;
								state_q      <= (count_q != '0) ? S_SCAN : S_DONE;
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// issue one read per cycle, compare the one from last cycle
					last_s1 <= (ptr_q + 1'b1 == count_q);
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (vld_s1 && last_s1) begin
						res_found_q <= hit_q | match;
						vld_s1      <= 1'b0;
						state_q     <= S_DONE;
					end else begin
						vld_s1 <= rd_en;
						if (vld_s1) begin
							hit_q <= hit_q | match;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Key register for the search
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= value;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
			depth_q  <= count_wide[DEPTH_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign depth_now = depth_q;

endmodule

[design/svs_checker.sv]
// ----------------------------------------------------------------------------
// svs_checker
// Port-level checks for the searchable value stack, bound to the top level.
// ----------------------------------------------------------------------------
module svs_checker
	import svs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic [OP_W-1:0]     opcode,
	input logic [VALUE_W-1:0]  value,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic                found,
	input logic [DEPTH_W-1:0]  depth_now
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(found) && $stable(depth_now))
		else $error("result changed while stalled");

	// One item in flight: the block stalls right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before the first finished");

	// The reserved status code never shows
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != ST_RSVD)
		else $error("reserved status code");

	// A hit only comes with status ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_OK)
		else $error("found set on a refused item");

endmodule

bind searchable_value_stack svs_checker u_svs_checker (.*);
